>>> src/wnre_pkg.sv
// ----------------------------------------------------------------------------
// wnre_pkg
// Shared types and constants of the wave number range estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package wnre_pkg;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_DIV_OFF,
        S_DIV_ADJ,
        S_TAKE,
        S_DIST,
        S_MSQ0,
        S_MSQ1,
        S_MSQ2,
        S_KGO,
        S_DIV_K,
        S_UPD,
        S_FIN
    } t_state;

    // Operand set loaded into the divider at start.
    typedef enum logic [1:0] {
        DIV_OFFSET,
        DIV_HEIGHT,
        DIV_WAVE
    } t_div_sel;

    // Squaring steps for the 48-bit distance product.
    typedef enum logic [1:0] {
        SQ_NONE,
        SQ_LOW,
        SQ_MID,
        SQ_HIGH
    } t_sq_step;

    typedef struct packed {
        logic      load_in;
        logic      eval;
        logic      div_start;
        t_div_sel  div_sel;
        logic      cap_off;
        logic      take;
        logic      scale;
        t_sq_step  sq_step;
        logic      upd;
        logic      finish;
    } t_cmd;

    typedef struct packed {
        logic exam_ok;
        logic pair;
        logic div_done;
        logic field_end;
        logic out_busy;
    } t_status;

    localparam int DIV_N_W = 66;
    localparam int DIV_D_W = 96;

    // pi^2 / g scaled by 2^64.
    localparam logic [DIV_N_W-1:0] KC = 66'd18565164097388282746;

    localparam logic [15:0] SPACING_RESET = 16'd256;

endpackage

`default_nettype wire

>>> src/wave_number_range_estimator_core.sv
// ----------------------------------------------------------------------------
// wave_number_range_estimator_core
// Estimates the range of wave numbers in an elevation field.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// s         in         tdata[15:0] elevation, tuser last_in_row, tlast last_in_field
// m         out        tdata[31:0] min, tdata[63:32] max, tuser found
// apb       in/out     register 0 at address 0: sample_spacing (Q8.8)
//
// A sample without an extremum is loaded, examined and finished. A sample that
// is an extremum also runs two 66-step divisions, and one that closes a pair
// a third division and the squaring. All divisions use the shared
// one-bit-a-cycle divider. Reset is synchronous, active low,
// and no clearing pass follows.
// The result waits in an output register; only a field end stalls on it.
// ----------------------------------------------------------------------------
`default_nettype none

module wave_number_range_estimator_core #(
    parameter int MAX_ROW_LEN = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,   // [15:0] elevation
    input  wire logic        i_s_tuser,   // last_in_row
    input  wire logic        i_s_tlast,   // last_in_field
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [63:0]      o_m_tdata,   // [31:0] min_wave_number, [63:32] max
    output logic             o_m_tuser,   // found
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import wnre_pkg::*;

    t_cmd        cmd;
    t_status     status;
    logic [15:0] spacing;
    logic [31:0] out_min, out_max;
    logic        cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr == 2'd0);
    assign prdata = (paddr == 2'd0) ? {16'd0, spacing} : 32'd0;

    wnre_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    wnre_dp #(
        .MAX_ROW_LEN (MAX_ROW_LEN)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_elevation     (i_s_tdata),
        .i_last_in_row   (i_s_tuser),
        .i_last_in_field (i_s_tlast),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (pwdata[15:0]),
        .o_spacing       (spacing),
        .o_out_valid     (o_m_tvalid),
        .i_out_ready     (i_m_tready),
        .o_min           (out_min),
        .o_max           (out_max),
        .o_found         (o_m_tuser)
    );

    assign o_m_tdata = {out_max, out_min};

endmodule

`default_nettype wire

>>> src/wnre_div.sv
// ----------------------------------------------------------------------------
// wnre_div
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// ----------------------------------------------------------------------------
`default_nettype none

module wnre_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [wnre_pkg::DIV_N_W-1:0]  i_dividend,
    input  wire logic [wnre_pkg::DIV_D_W-1:0]  i_divisor,
    output logic                               o_done,
    output logic [wnre_pkg::DIV_N_W-1:0]       o_quotient
);
    import wnre_pkg::*;

    logic [DIV_D_W:0]   r_rem, n_rem, rem_s;
    logic [DIV_N_W-1:0] r_dvd;
    logic [DIV_D_W-1:0] r_dsr;
    logic [DIV_N_W-1:0] r_q;
    logic [6:0]         r_cnt;
    logic               r_busy, r_done;
    logic               ge;

    always_comb begin
        rem_s = {r_rem[DIV_D_W-1:0], r_dvd[DIV_N_W-1]};
        ge    = rem_s >= {1'b0, r_dsr};
        n_rem = ge ? rem_s - {1'b0, r_dsr} : rem_s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'(DIV_N_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[DIV_N_W-2:0], 1'b0};
            r_q   <= {r_q[DIV_N_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

`default_nettype wire

>>> src/wnre_ctrl.sv
// ----------------------------------------------------------------------------
// wnre_ctrl
// Sequencer: steps each item through fit, merge, wave number and result.
// ----------------------------------------------------------------------------
`default_nettype none

module wnre_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire wnre_pkg::t_status  i_status,
    output wnre_pkg::t_cmd          o_cmd
);
    import wnre_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_status.exam_ok) begin
                    o_cmd.eval      = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_OFFSET;
                    n_state         = S_DIV_OFF;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DIV_OFF: begin
                if (i_status.div_done) begin
                    o_cmd.cap_off   = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_HEIGHT;
                    n_state         = S_DIV_ADJ;
                end
            end
            S_DIV_ADJ: begin
                if (i_status.div_done) begin
                    n_state = S_TAKE;
                end
            end
            S_TAKE: begin
                o_cmd.take = 1'b1;
                n_state    = i_status.pair ? S_DIST : S_FIN;
            end
            S_DIST: begin
                o_cmd.scale = 1'b1;
                n_state     = S_MSQ0;
            end
            S_MSQ0: begin
                o_cmd.sq_step = SQ_LOW;
                n_state       = S_MSQ1;
            end
            S_MSQ1: begin
                o_cmd.sq_step = SQ_MID;
                n_state       = S_MSQ2;
            end
            S_MSQ2: begin
                o_cmd.sq_step = SQ_HIGH;
                n_state       = S_KGO;
            end
            S_KGO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_WAVE;
                n_state         = S_DIV_K;
            end
            S_DIV_K: begin
                if (i_status.div_done) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                // A field end waits until the previous result has been taken.
                if (!(i_status.field_end && i_status.out_busy)) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

>>> src/wnre_dp.sv
// ----------------------------------------------------------------------------
// wnre_dp
// Datapath: sample window, parabola fit, extremum merge, wave number range.
// ----------------------------------------------------------------------------
`default_nettype none

module wnre_dp #(
    parameter int MAX_ROW_LEN = 4096
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire wnre_pkg::t_cmd     i_cmd,
    output wnre_pkg::t_status       o_status,
    input  wire logic [15:0]        i_elevation,
    input  wire logic               i_last_in_row,
    input  wire logic               i_last_in_field,
    input  wire logic               i_cfg_we,
    input  wire logic [15:0]        i_cfg_data,
    output logic [15:0]             o_spacing,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [31:0]             o_min,
    output logic [31:0]             o_max,
    output logic                    o_found
);
    import wnre_pkg::*;

    localparam int RPW = $clog2(MAX_ROW_LEN + 1);

    logic [15:0]      r_spacing;
    logic [15:0]      r_raw, r_older, r_newer;
    logic             r_row_end, r_field_end;
    logic [RPW-1:0]   r_rp;
    logic             r_have_cur, r_have_prev, r_any;
    logic [31:0]      r_cur_pos, r_prev_pos, r_cur_h;
    logic [31:0]      r_min, r_max;
    logic [31:0]      r_dsq;
    logic [16:0]      r_off_q;
    logic             r_off_neg, r_adj_neg;
    logic [31:0]      r_dist;
    logic [47:0]      r_m;
    logic [95:0]      r_msq;
    logic             r_out_valid;
    logic [31:0]      r_out_min, r_out_max;
    logic             r_out_found;

    // Fit of the three-sample window.
    logic signed [16:0] dw1, dw2, diff;
    logic signed [17:0] sum;
    logic [16:0]        mag;
    logic [15:0]        absdiff;
    logic               in_row, cond;
    logic [15:0]        center;

    always_comb begin
        dw1     = $signed({r_newer[15], r_newer}) - $signed({r_older[15], r_older});
        dw2     = $signed({r_newer[15], r_newer}) - $signed({r_raw[15], r_raw});
        diff    = $signed({r_raw[15], r_raw}) - $signed({r_older[15], r_older});
        sum     = $signed({dw1[16], dw1}) + $signed({dw2[16], dw2});
        mag     = sum[17] ? 17'(-sum) : sum[16:0];
        absdiff = diff[16] ? 16'(-diff) : diff[15:0];
        in_row  = (r_rp < RPW'(MAX_ROW_LEN)) && (r_rp >= RPW'(2));
        cond    = ((dw1 > 0) == (dw2 > 0)) && (sum != 0);
        center  = 16'(r_rp - RPW'(1));
    end

    // Divider operands.
    logic               div_done;
    logic [DIV_N_W-1:0] div_q, div_n;
    logic [DIV_D_W-1:0] div_d;

    always_comb begin
        unique case (i_cmd.div_sel)
            DIV_OFFSET: begin
                div_n = DIV_N_W'({absdiff, 15'd0});
                div_d = DIV_D_W'(mag);
            end
            DIV_HEIGHT: begin
                div_n = DIV_N_W'({r_dsq, 5'd0});
                div_d = DIV_D_W'(mag);
            end
            DIV_WAVE: begin
                div_n = KC;
                div_d = r_msq;
            end
            default: begin
                div_n = '0;
                div_d = '0;
            end
        endcase
    end

    wnre_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_n),
        .i_divisor  (div_d),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // Vertex and merge decision.
    logic [31:0] off_s, adj_s, pos, h, abs_h, abs_cur, gap;
    logic        h_pos, cur_pos_sign, same, pair;

    always_comb begin
        off_s        = r_off_neg ? -{15'd0, r_off_q} : {15'd0, r_off_q};
        adj_s        = r_adj_neg ? -div_q[31:0] : div_q[31:0];
        pos          = {center, 16'd0} + off_s;
        h            = {{8{r_newer[15]}}, r_newer, 8'd0} + adj_s;
        h_pos        = !h[31] && (h != 32'd0);
        cur_pos_sign = !r_cur_h[31] && (r_cur_h != 32'd0);
        same         = h_pos == cur_pos_sign;
        abs_h        = h[31] ? -h : h;
        abs_cur      = r_cur_h[31] ? -r_cur_h : r_cur_h;
        pair         = r_have_cur && !same && r_have_prev;
        gap          = (r_cur_pos >= r_prev_pos) ? r_cur_pos - r_prev_pos
                                                 : r_prev_pos - r_cur_pos;
    end

    logic [31:0] k;
    assign k = (div_q[DIV_N_W-1:32] != '0) ? 32'hFFFF_FFFF : div_q[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spacing   <= SPACING_RESET;
            r_older     <= '0;
            r_newer     <= '0;
            r_rp        <= '0;
            r_have_cur  <= 1'b0;
            r_cur_pos   <= '0;
            r_cur_h     <= '0;
            r_prev_pos  <= '0;
            r_have_prev <= 1'b0;
            r_min       <= 32'hFFFF_FFFF;
            r_max       <= '0;
            r_any       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_spacing <= i_cfg_data;
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.take) begin
                if (!r_have_cur) begin
                    r_have_cur <= 1'b1;
                    r_cur_pos  <= pos;
                    r_cur_h    <= h;
                end else if (same) begin
                    if (abs_cur < abs_h) begin
                        r_cur_pos <= pos;
                        r_cur_h   <= h;
                    end
                end else begin
                    r_prev_pos  <= r_cur_pos;
                    r_have_prev <= 1'b1;
                    r_cur_pos   <= pos;
                    r_cur_h     <= h;
                end
            end
            if (i_cmd.upd) begin
                if (k < r_min) r_min <= k;
                if (k > r_max) r_max <= k;
                r_any <= 1'b1;
            end
            if (i_cmd.finish) begin
                if (r_rp < RPW'(MAX_ROW_LEN)) begin
                    r_older <= r_newer;
                    r_newer <= r_raw;
                    r_rp    <= r_rp + RPW'(1);
                end
                if (r_row_end || r_field_end) begin
                    r_rp <= '0;
                end
                if (r_field_end) begin
                    r_out_valid <= 1'b1;
                    r_older     <= '0;
                    r_newer     <= '0;
                    r_have_cur  <= 1'b0;
                    r_cur_pos   <= '0;
                    r_cur_h     <= '0;
                    r_prev_pos  <= '0;
                    r_have_prev <= 1'b0;
                    r_min       <= 32'hFFFF_FFFF;
                    r_max       <= '0;
                    r_any       <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_raw       <= i_elevation;
            r_row_end   <= i_last_in_row;
            r_field_end <= i_last_in_field;
        end
        if (i_cmd.eval) begin
            r_dsq     <= absdiff * absdiff;
            r_off_neg <= diff[16] != sum[17];
            r_adj_neg <= sum[17];
        end
        if (i_cmd.cap_off) begin
            r_off_q <= div_q[16:0];
        end
        if (i_cmd.take) begin
            r_dist <= gap;
        end
        if (i_cmd.scale) begin
            r_m <= r_dist * r_spacing;
        end
        unique case (i_cmd.sq_step)
            SQ_LOW:  r_msq <= 96'(48'(r_m[23:0]) * 48'(r_m[23:0]));
            SQ_MID:  r_msq <= r_msq + {23'd0, 48'(r_m[47:24]) * 48'(r_m[23:0]), 25'd0};
            SQ_HIGH: r_msq <= r_msq + {48'(r_m[47:24]) * 48'(r_m[47:24]), 48'd0};
            default: r_msq <= r_msq;
        endcase
        if (i_cmd.finish && r_field_end) begin
            r_out_min   <= r_any ? r_min : 32'd0;
            r_out_max   <= r_any ? r_max : 32'd0;
            r_out_found <= r_any;
        end
    end

    always_comb begin
        o_status.exam_ok   = in_row && cond;
        o_status.pair      = pair;
        o_status.div_done  = div_done;
        o_status.field_end = r_field_end;
        o_status.out_busy  = r_out_valid && !i_out_ready;
    end

    assign o_spacing   = r_spacing;
    assign o_out_valid = r_out_valid;
    assign o_min       = r_out_min;
    assign o_max       = r_out_max;
    assign o_found     = r_out_found;

endmodule

`default_nettype wire

>>> src/wnre_checker.sv
// ----------------------------------------------------------------------------
// wnre_checker
// Port-level checks of the wave number range estimator.
// ----------------------------------------------------------------------------
`default_nettype none

module wnre_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [63:0] o_m_tdata,
    input wire logic        o_m_tuser,
    input wire logic        pready
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata == 64'd0)
        else $error("empty result carries nonzero range");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata[31:0] <= o_m_tdata[63:32])
        else $error("minimum exceeds maximum");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    a_ready: assert property (@(posedge i_clk) pready)
        else $error("register port not ready");

endmodule

bind wave_number_range_estimator_core wnre_checker u_wnre_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .pready     (pready)
);

`default_nettype wire

>>> verif/wave_number_range_estimator_core_checker.sv
// ----------------------------------------------------------------------------
// Wave number range checker
// Watches the sample and result streams and the register port, predicts the
// range result of every field and compares it with what the core delivers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wave_number_range_estimator_core_checker #(
    parameter int MAX_ROW_LEN = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,
    input  logic        i_s_tuser,
    input  logic        i_s_tlast,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [63:0] i_m_tdata,
    input  logic        i_m_tuser,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [1:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [65:0] K_SCALED = 66'd18565164097388282746;

    typedef struct packed {
        logic [31:0] kmin;
        logic [31:0] kmax;
        logic        found;
    } range_t;

    range_t range_q[$];

    logic [15:0] spacing;
    logic [15:0] smp_old, smp_new;
    int unsigned row_cnt;
    logic        cur_ok, prev_ok, any_k;
    logic [31:0] cur_pos, prev_pos, k_lo, k_hi;
    logic signed [31:0] cur_h;

    assign o_pending = range_q.size();

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp_v);
        $display("MISMATCH %s: got %h, expected %h", what, got, exp_v);
        o_fail_count++;
    endtask

    function automatic logic [31:0] wave_k(input logic [31:0] gap);
        logic [47:0]  m;
        logic [95:0]  msq;
        logic [161:0] q;
        m = gap * spacing;
        if (m == 0) return 32'hFFFF_FFFF;
        msq = m * m;
        q = {96'd0, K_SCALED} / {66'd0, msq};
        return (q > 162'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    task automatic merge_extremum(input logic [31:0] pos, input logic signed [31:0] h);
        logic [31:0] gap, k, ma, mb;
        if (!cur_ok) begin
            cur_ok = 1; cur_pos = pos; cur_h = h;
            return;
        end
        if ((cur_h > 0) == (h > 0)) begin
            ma = cur_h < 0 ? -cur_h : cur_h;
            mb = h < 0 ? -h : h;
            if (ma < mb) begin
                cur_pos = pos; cur_h = h;
            end
            return;
        end
        if (prev_ok) begin
            gap = cur_pos >= prev_pos ? cur_pos - prev_pos : prev_pos - cur_pos;
            k = wave_k(gap);
            if (k < k_lo) k_lo = k;
            if (k > k_hi) k_hi = k;
            any_k = 1;
        end
        prev_pos = cur_pos; prev_ok = 1;
        cur_pos = pos; cur_h = h;
    endtask

    task automatic check_center(input logic signed [15:0] l, input logic signed [15:0] c,
                                input logic signed [15:0] r, input int unsigned idx);
        longint d1, d2, s, df, mag, off, adj;
        d1 = longint'(c) - l;
        d2 = longint'(c) - r;
        s = d1 + d2;
        df = d1 - d2;
        if ((d1 > 0) != (d2 > 0) || s == 0) return;
        mag = s < 0 ? -s : s;
        off = (df < 0 ? -df : df) * 32768 / mag;
        if ((df < 0) != (s < 0)) off = -off;
        adj = (df * df * 32) / mag;
        if (s < 0) adj = -adj;
        merge_extremum(32'(longint'(idx) * 65536 + off), 32'(longint'(c) * 256 + adj));
    endtask

    task automatic clear_field();
        smp_old = 0; smp_new = 0; row_cnt = 0;
        cur_ok = 0; cur_pos = 0; cur_h = 0; prev_pos = 0; prev_ok = 0;
        k_lo = 32'hFFFF_FFFF; k_hi = 0; any_k = 0;
    endtask

    always @(posedge i_clk) begin
        range_t r, exp_r;
        if (!i_rst_n) begin
            spacing <= 16'd256;
            clear_field();
            o_fail_count = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_paddr == 2'd0)
                spacing <= i_pwdata[15:0];
            if (i_s_tvalid && i_s_tready) begin
                if (row_cnt < MAX_ROW_LEN) begin
                    if (row_cnt >= 2)
                        check_center(smp_old, smp_new, i_s_tdata, row_cnt - 1);
                    smp_old = smp_new;
                    smp_new = i_s_tdata;
                    row_cnt++;
                end
                if (i_s_tuser || i_s_tlast) row_cnt = 0;
                if (i_s_tlast) begin
                    r.kmin = any_k ? k_lo : 0;
                    r.kmax = any_k ? k_hi : 0;
                    r.found = any_k;
                    range_q.push_back(r);
                    clear_field();
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                if (range_q.size() == 0) begin
                    report("unexpected result", i_m_tdata, 0);
                end else begin
                    exp_r = range_q.pop_front();
                    if (i_m_tdata[31:0] !== exp_r.kmin)
                        report("min_wave_number", i_m_tdata[31:0], exp_r.kmin);
                    if (i_m_tdata[63:32] !== exp_r.kmax)
                        report("max_wave_number", i_m_tdata[63:32], exp_r.kmax);
                    if (i_m_tuser !== exp_r.found)
                        report("found", i_m_tuser, exp_r.found);
                end
            end
        end
    end

endmodule

>>> verif/wave_number_range_estimator_core_tb.sv
// ----------------------------------------------------------------------------
// Wave number range estimator testbench
// Streams directed and random elevation fields under several idling mixes
// and spacing settings; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wave_number_range_estimator_core_tb;

    localparam int WATCHDOG_LIMIT = 200000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [15:0] s_tdata = 0;
    logic        s_tuser = 0;
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [63:0] m_tdata;
    logic        m_tuser;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [1:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count, pending;
    int          send_idle_pct = 0, stall_pct = 0;
    bit          hold_off = 0;
    int          quiet_cycles = 0;

    always #2 i_clk = ~i_clk;

    wave_number_range_estimator_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_s_tuser(s_tuser), .i_s_tlast(s_tlast),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready), .o_m_tdata(m_tdata),
        .o_m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    wave_number_range_estimator_core_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_s_tuser(s_tuser), .i_s_tlast(s_tlast),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .i_m_tuser(m_tuser),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .o_fail_count(fail_count), .o_pending(pending)
    );

    // Result side: random stalls, or a long hold-off when asked.
    always @(posedge i_clk) begin
        if (!i_rst_n)
            m_tready <= 0;
        else
            m_tready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end

    // Watchdog on cycles without any accepted item.
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_spacing(input logic [15:0] value);
        @(posedge i_clk);
        psel <= 1; pwrite <= 1; paddr <= 0; pwdata <= {16'd0, value};
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    // Leaves tvalid high after the accept; the next sample or drain decides.
    task automatic send_sample(input logic [15:0] z, input logic row_end, input logic fld_end);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(posedge i_clk);
        end
        s_tvalid <= 1; s_tdata <= z; s_tuser <= row_end; s_tlast <= fld_end;
        do @(posedge i_clk); while (!s_tready);
    endtask

    // Waits for all results, then lets the slowest sample drain.
    task automatic drain();
        s_tvalid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    function automatic logic [15:0] wave_sample(input int j, input int period, input int amp);
        int ph;
        ph = j % period;
        return 16'(ph < period / 2 ? amp * ph : amp * (period - ph)) - 16'(amp * period / 4)
               + 16'($urandom_range(15));
    endfunction

    // One random field: mostly wavy rows, sometimes pure noise.
    task automatic send_field(input int rows);
        int len, per, amp;
        bit noisy;
        for (int r = 0; r < rows; r++) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : $urandom_range(6, 24);
            per = $urandom_range(4, 12);
            amp = $urandom_range(1, 3000);
            noisy = $urandom_range(4) == 0;
            for (int j = 0; j < len; j++)
                send_sample(noisy ? 16'($urandom) : wave_sample(j, per, amp),
                            j == len - 1 && $urandom_range(7) != 0,
                            r == rows - 1 && j == len - 1);
        end
    endtask

    initial begin
        logic [15:0] spacings[5] = '{16'd256, 16'd1, 16'd65535, 16'd0, 16'd77};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: extremes, flat samples, zero distance, short rows.
        send_sample(16'h7FFF, 0, 0); send_sample(16'h8000, 0, 0);
        send_sample(16'h7FFF, 0, 0); send_sample(16'h8000, 0, 0);
        send_sample(16'h7FFF, 0, 0); send_sample(16'h0005, 0, 0);
        send_sample(16'h0005, 0, 0); send_sample(16'h0005, 1, 0);
        send_sample(16'h0001, 1, 0); send_sample(16'h0002, 0, 0);
        send_sample(16'h0100, 0, 0); send_sample(16'hFF00, 0, 0);
        send_sample(16'h0100, 0, 0); send_sample(16'hFF00, 0, 1);
        send_sample(16'h1234, 0, 1);
        drain();
        write_spacing(16'd0);
        send_sample(16'h0000, 0, 0); send_sample(16'h0100, 0, 0);
        send_sample(16'h0000, 0, 0); send_sample(16'h0100, 0, 0);
        send_sample(16'h0000, 0, 0); send_sample(16'h0100, 0, 1);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            write_spacing(spacings[ph % 5]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 45; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 45; end
                default: begin send_idle_pct = 34; stall_pct = 34; end
            endcase
            if (ph == 3) begin
                // Receiver holds off while fields keep arriving.
                hold_off = 1;
                fork
                    begin repeat (20000) @(posedge i_clk); hold_off = 0; end
                    for (int f = 0; f < 4; f++) send_field(2);
                join
            end
            for (int f = 0; f < 6; f++)
                send_field($urandom_range(1, 3));
            drain();
        end

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> files.f
src/wnre_pkg.sv
src/wnre_div.sv
src/wnre_ctrl.sv
src/wnre_dp.sv
src/wave_number_range_estimator_core.sv
src/wnre_checker.sv
verif/wave_number_range_estimator_core_checker.sv
verif/wave_number_range_estimator_core_tb.sv
